[rtl/hex_record_line_encoder_assert.svh]
// assertion macros for the hex record line encoder
`ifndef HEX_RECORD_LINE_ENCODER_ASSERT_SVH
`define HEX_RECORD_LINE_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
`define HRLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrle assertion failed");
`define HRLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrle assertion failed");
`else
`define HRLE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HRLE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/hrle_pkg.sv]
package hrle_pkg;

    localparam logic [1:0] CMD_START    = 2'd0;
    localparam logic [1:0] CMD_DATA     = 2'd1;
    localparam logic [1:0] CMD_END_SEC  = 2'd2;
    localparam logic [1:0] CMD_END_FILE = 2'd3;

    localparam logic [1:0] JOB_REC = 2'd0;
    localparam logic [1:0] JOB_END = 2'd1;
    localparam logic [1:0] JOB_ERR = 2'd2;

    localparam logic [6:0] CHAR_COLON = 7'h3A;
    localparam logic [6:0] CHAR_NL    = 7'h0A;
    localparam logic [6:0] CHAR_NUL   = 7'h00;

    localparam int unsigned END_LEN = 12;
    localparam logic [3:0] END_LAST = 4'd11;

    localparam logic [6:0] END_REC [END_LEN] = '{
        7'h3A, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30,
        7'h30, 7'h30, 7'h31, 7'h46, 7'h46, 7'h0A
    };

    typedef struct packed {
        logic        go;
        logic [1:0]  kind;
        logic [15:0] addr;
    } job_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] ch;
        if (nib < 4'd10)
        begin
            ch = 7'h30 + 7'(nib);
        end
        else
        begin
            ch = 7'h37 + 7'(nib);
        end
        return ch;
    endfunction

endpackage

[rtl/hrle_buf.sv]
module hrle_buf #(
    parameter int DEPTH = 24,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/hrle_fmt.sv]
module hrle_fmt #(
    parameter int CW = 5
) (
    input  logic           clk,
    input  logic           rst_n,
    input  hrle_pkg::job_t job,
    input  logic [CW-1:0]  job_count,
    input  logic [7:0]     rd_data,
    output logic [CW-1:0]  rd_idx,
    output logic           busy,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [6:0]     out_char,
    output logic           last_char,
    output logic           error
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_COLON = 3'd1;
    localparam logic [2:0] ST_HI    = 3'd2;
    localparam logic [2:0] ST_LO    = 3'd3;
    localparam logic [2:0] ST_NL    = 3'd4;
    localparam logic [2:0] ST_END   = 3'd5;
    localparam logic [2:0] ST_ERR   = 3'd6;

    localparam logic [2:0] FLD_COUNT = 3'd0;
    localparam logic [2:0] FLD_AHI   = 3'd1;
    localparam logic [2:0] FLD_ALO   = 3'd2;
    localparam logic [2:0] FLD_TYPE  = 3'd3;
    localparam logic [2:0] FLD_DATA  = 3'd4;
    localparam logic [2:0] FLD_CSUM  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [2:0]    field_reg, field_next;
    logic [15:0]   addr_reg, addr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    byte_reg, byte_next;
    logic [3:0]    end_idx_reg, end_idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [6:0]    char_reg, char_next;
    logic          last_reg, last_next;
    logic          err_reg, err_next;
    logic          advance;
    logic [7:0]    sel_byte;

    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        unique case (field_reg)
            FLD_COUNT: sel_byte = 8'(count_reg);
            FLD_AHI:   sel_byte = addr_reg[15:8];
            FLD_ALO:   sel_byte = addr_reg[7:0];
            FLD_DATA:  sel_byte = rd_data;
            FLD_CSUM:  sel_byte = 8'h00 - sum_reg;
            default:   sel_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        field_next     = field_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        byte_next      = byte_reg;
        end_idx_next   = end_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        err_next       = err_reg;

        if (advance && state_reg != ST_IDLE)
        begin
            out_valid_next = 1'b1;
            last_next      = 1'b0;
            err_next       = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job.go)
                begin
                    addr_next    = job.addr;
                    count_next   = job_count;
                    idx_next     = '0;
                    sum_next     = 8'h00;
                    field_next   = FLD_COUNT;
                    end_idx_next = 4'd0;
                    unique case (job.kind)
                        hrle_pkg::JOB_REC: state_next = ST_COLON;
                        hrle_pkg::JOB_END: state_next = ST_END;
                        default:           state_next = ST_ERR;
                    endcase
                end
            end
            ST_COLON:
            begin
                if (advance)
                begin
                    char_next  = hrle_pkg::CHAR_COLON;
                    state_next = ST_HI;
                end
            end
            ST_HI:
            begin
                if (advance)
                begin
                    char_next  = hrle_pkg::hex_char(sel_byte[7:4]);
                    byte_next  = sel_byte;
                    sum_next   = sum_reg + sel_byte;
                    state_next = ST_LO;
                    if (field_reg == FLD_DATA)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            ST_LO:
            begin
                if (advance)
                begin
                    char_next  = hrle_pkg::hex_char(byte_reg[3:0]);
                    state_next = ST_HI;
                    unique case (field_reg)
                        FLD_COUNT: field_next = FLD_AHI;
                        FLD_AHI:   field_next = FLD_ALO;
                        FLD_ALO:   field_next = FLD_TYPE;
                        FLD_TYPE:
                            field_next = (count_reg == '0) ? FLD_CSUM : FLD_DATA;
                        FLD_DATA:
                            field_next = (idx_reg == count_reg) ? FLD_CSUM : FLD_DATA;
                        default:   state_next = ST_NL;
                    endcase
                end
            end
            ST_NL:
            begin
                if (advance)
                begin
                    char_next  = hrle_pkg::CHAR_NL;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_END:
            begin
                if (advance)
                begin
                    char_next    = hrle_pkg::END_REC[end_idx_reg];
                    last_next    = (end_idx_reg == hrle_pkg::END_LAST);
                    end_idx_next = end_idx_reg + 4'd1;
                    if (end_idx_reg == hrle_pkg::END_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (advance)
                begin
                    char_next  = hrle_pkg::CHAR_NUL;
                    err_next   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        field_reg   <= field_next;
        addr_reg    <= addr_next;
        count_reg   <= count_next;
        idx_reg     <= idx_next;
        sum_reg     <= sum_next;
        byte_reg    <= byte_next;
        end_idx_reg <= end_idx_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        err_reg     <= err_next;
    end

    assign rd_idx    = idx_reg;
    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;
    assign error     = err_reg;

endmodule

[rtl/hex_record_line_encoder.sv]
// hex record line encoder: byte stream in, Intel HEX text out, one character per beat
// input channel (in_valid / in_stall): cmd, data_byte, start_address
//   start section opens a section at start_address, or gives one error beat if one is open
//   data byte is buffered; the beat that fills the buffer also starts a data record
//   end section flushes the buffer as a record, even an empty one
//   end file sends the fixed end record ":00000001FF" and a newline
// output channel (out_valid / out_stall): out_char, last_char on each newline, error
// a record of n data bytes is 2n+12 characters, the formatter sequencer with its shared
//   checksum adder and hex digit lookup producing one character per cycle while out_stall
//   is low
// a command with no output is taken without raising in_stall; the first character passes
//   through the sequencer state register and then the output register after the beat that starts a record
// in_stall is high while the sequencer is busy with a run
// the output register holds its beat while out_stall is high and the sequencer waits
// reset clears the count, the load address, the open flag and the sequencer;
//   the byte buffer is not cleared and is only read after being written
module hex_record_line_encoder #(
    parameter int RECORD_BYTES = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic [15:0] start_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  out_char,
    output logic        last_char,
    output logic        error
);

`include "hex_record_line_encoder_assert.svh"

    localparam int CW = $clog2(RECORD_BYTES + 1);
    localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    logic [CW-1:0]  fill_count_reg, fill_count_next;
    logic [15:0]    load_address_reg, load_address_next;
    logic           section_open_reg, section_open_next;
    logic           busy;
    logic           accept;
    logic [CW-1:0]  fill_inc;
    logic [CW-1:0]  rd_idx;
    logic [7:0]     rd_data;
    logic           wr_en;
    hrle_pkg::job_t job;
    logic [CW-1:0]  job_count;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;
    assign fill_inc = fill_count_reg + CW'(1);
    assign wr_en    = accept && (cmd == hrle_pkg::CMD_DATA);

    always_comb
    begin
        fill_count_next   = fill_count_reg;
        load_address_next = load_address_reg;
        section_open_next = section_open_reg;
        job.go            = 1'b0;
        job.kind          = hrle_pkg::JOB_REC;
        job.addr          = load_address_reg;
        job_count         = fill_count_reg;

        if (accept)
        begin
            unique case (cmd)
                hrle_pkg::CMD_START:
                begin
                    if (section_open_reg)
                    begin
                        job.go   = 1'b1;
                        job.kind = hrle_pkg::JOB_ERR;
                    end
                    else
                    begin
                        load_address_next = start_address;
                        fill_count_next   = '0;
                        section_open_next = 1'b1;
                    end
                end
                hrle_pkg::CMD_DATA:
                begin
                    if (fill_inc == CW'(RECORD_BYTES))
                    begin
                        job.go            = 1'b1;
                        job_count         = fill_inc;
                        load_address_next = load_address_reg + 16'(RECORD_BYTES);
                        fill_count_next   = '0;
                    end
                    else
                    begin
                        fill_count_next = fill_inc;
                    end
                end
                hrle_pkg::CMD_END_SEC:
                begin
                    job.go            = 1'b1;
                    section_open_next = 1'b0;
                    load_address_next = load_address_reg + 16'(fill_count_reg);
                    fill_count_next   = '0;
                end
                default:
                begin
                    job.go   = 1'b1;
                    job.kind = hrle_pkg::JOB_END;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg   <= '0;
            load_address_reg <= 16'h0000;
            section_open_reg <= 1'b0;
        end
        else
        begin
            fill_count_reg   <= fill_count_next;
            load_address_reg <= load_address_next;
            section_open_reg <= section_open_next;
        end
    end

    hrle_buf #(
        .DEPTH (RECORD_BYTES),
        .AW    (AW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_count_reg[AW-1:0]),
        .wr_data (data_byte),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    hrle_fmt #(
        .CW (CW)
    ) u_fmt (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_count (job_count),
        .rd_data   (rd_data),
        .rd_idx    (rd_idx),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last_char (last_char),
        .error     (error)
    );

    `HRLE_ASSERT_IMP(a_fill_below_depth, clk, rst_n, 1'b1, fill_count_reg < RECORD_BYTES)
    `HRLE_ASSERT_NXT(a_end_file_busy, clk, rst_n, accept && cmd == hrle_pkg::CMD_END_FILE, in_stall)
    `HRLE_ASSERT_IMP(a_error_beat_clean, clk, rst_n, out_valid && error, out_char == hrle_pkg::CHAR_NUL && !last_char)

endmodule

[tb/sv/hex_record_line_encoder_tb.sv]
module hex_record_line_encoder_tb;

    localparam int REC_LEN = 24;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic [15:0] start_address;
    } hex_item_t;

    typedef struct {
        logic [6:0] ch;
        logic       last;
        logic       err;
    } hex_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = hrle_pkg::CMD_START;
    logic [7:0]  data_byte = 8'h00;
    logic [15:0] start_address = 16'h0000;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [6:0]  out_char;
    logic        last_char;
    logic        error;

    hex_item_t pending_items [$];
    hex_char_t exp_chars [$];
    int        mismatch_count = 0;

    // predictor state
    logic [7:0]  rec_buf [REC_LEN];
    logic [4:0]  rec_fill = '0;
    logic [15:0] rec_addr = '0;
    logic        sec_open = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int stall_tick = 0;

    hex_record_line_encoder #(
        .RECORD_BYTES(REC_LEN)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .data_byte(data_byte),
        .start_address(start_address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_char(out_char),
        .last_char(last_char),
        .error(error)
    );

    always #5 clk = ~clk;

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic push_char(input logic [6:0] ch, input logic last, input logic err);
        hex_char_t c;
        c.ch = ch;
        c.last = last;
        c.err = err;
        exp_chars.push_back(c);
    endtask

    task automatic push_hex(input logic [7:0] b, inout logic [7:0] sum);
        string digits;
        digits = "0123456789ABCDEF";
        sum = sum + b;
        push_char(7'(digits[b[7:4]]), 1'b0, 1'b0);
        push_char(7'(digits[b[3:0]]), 1'b0, 1'b0);
    endtask

    task automatic flush_record();
        logic [7:0] sum;
        logic [7:0] chk;
        sum = 8'h00;
        push_char(hrle_pkg::CHAR_COLON, 1'b0, 1'b0);
        push_hex(8'(rec_fill), sum);
        push_hex(rec_addr[15:8], sum);
        push_hex(rec_addr[7:0], sum);
        push_hex(8'h00, sum);
        for (int i = 0; i < int'(rec_fill); i++)
        begin
            push_hex(rec_buf[i], sum);
        end
        chk = 8'h00 - sum;
        push_hex(chk, sum);
        push_char(hrle_pkg::CHAR_NL, 1'b1, 1'b0);
        rec_addr = rec_addr + 16'(rec_fill);
        rec_fill = '0;
    endtask

    task automatic encode_item(input hex_item_t it);
        string end_text;
        end_text = ":00000001FF";
        case (it.cmd)
            hrle_pkg::CMD_START:
            begin
                if (sec_open)
                begin
                    push_char(hrle_pkg::CHAR_NUL, 1'b0, 1'b1);
                end
                else
                begin
                    rec_addr = it.start_address;
                    rec_fill = '0;
                    sec_open = 1'b1;
                end
            end
            hrle_pkg::CMD_DATA:
            begin
                if (rec_fill < 5'(REC_LEN))
                begin
                    rec_buf[rec_fill] = it.data_byte;
                end
                rec_fill = rec_fill + 5'd1;
                if (rec_fill >= 5'(REC_LEN))
                begin
                    flush_record();
                end
            end
            hrle_pkg::CMD_END_SEC:
            begin
                sec_open = 1'b0;
                flush_record();
            end
            default:
            begin
                for (int i = 0; i < end_text.len(); i++)
                begin
                    push_char(7'(end_text[i]), 1'b0, 1'b0);
                end
                push_char(hrle_pkg::CHAR_NL, 1'b1, 1'b0);
            end
        endcase
    endtask

    task automatic queue_item(input logic [1:0] c, input logic [7:0] b, input logic [15:0] a);
        hex_item_t it;
        it.cmd = c;
        it.data_byte = b;
        it.start_address = a;
        pending_items.push_back(it);
    endtask

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rnd_addr();
        if ($urandom_range(0, 4) == 0)
        begin
            return 16'($urandom_range(16'hFFC0, 16'hFFFF));
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                encode_item(pending_items.pop_front());
            end
            if (in_valid && in_stall)
            begin
                // hold the stalled beat
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_valid <= 1'b1;
                cmd <= pending_items[0].cmd;
                data_byte <= pending_items[0].data_byte;
                start_address <= pending_items[0].start_address;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor and output stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (exp_chars.size() == 0)
                begin
                    report("beat with nothing expected", 16'(out_char), 16'h0);
                end
                else
                begin
                    if (out_char !== exp_chars[0].ch)
                    begin
                        report("out_char", 16'(out_char), 16'(exp_chars[0].ch));
                    end
                    if (last_char !== exp_chars[0].last)
                    begin
                        report("last_char", 16'(last_char), 16'(exp_chars[0].last));
                    end
                    if (error !== exp_chars[0].err)
                    begin
                        report("error", 16'(error), 16'(exp_chars[0].err));
                    end
                    void'(exp_chars.pop_front());
                end
            end
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 150);
            end
            else
            begin
                mode_left--;
            end
            stall_tick++;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ((stall_tick % 8) < 3);
            endcase
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        int r;
        int n;
        // full record across the address wrap, error start, flushes, end record
        queue_item(hrle_pkg::CMD_START, rnd_byte(), 16'hFFF0);
        queue_item(hrle_pkg::CMD_START, rnd_byte(), 16'h0000);
        for (int i = 0; i < REC_LEN; i++)
        begin
            queue_item(hrle_pkg::CMD_DATA,
                       (i == 0) ? 8'h00 : (i == REC_LEN - 1) ? 8'hFF : rnd_byte(),
                       rnd_addr());
        end
        queue_item(hrle_pkg::CMD_END_SEC, rnd_byte(), rnd_addr());
        queue_item(hrle_pkg::CMD_DATA, 8'hA5, 16'hFFFF);
        queue_item(hrle_pkg::CMD_END_SEC, rnd_byte(), rnd_addr());
        queue_item(hrle_pkg::CMD_END_FILE, rnd_byte(), rnd_addr());

        while (pending_items.size() < 250)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                queue_item(hrle_pkg::CMD_START, rnd_byte(), rnd_addr());
                n = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 30) : $urandom_range(31, 60);
                for (int i = 0; i < n; i++)
                begin
                    queue_item(hrle_pkg::CMD_DATA, rnd_byte(), rnd_addr());
                end
                queue_item(hrle_pkg::CMD_END_SEC, rnd_byte(), rnd_addr());
                if ($urandom_range(0, 5) == 0)
                begin
                    queue_item(hrle_pkg::CMD_END_FILE, rnd_byte(), rnd_addr());
                end
            end
            else if (r < 85)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    queue_item(hrle_pkg::CMD_START, rnd_byte(), rnd_addr());
                    queue_item(hrle_pkg::CMD_START, rnd_byte(), rnd_addr());
                    n = $urandom_range(0, 5);
                    for (int i = 0; i < n; i++)
                    begin
                        queue_item(hrle_pkg::CMD_DATA, rnd_byte(), rnd_addr());
                    end
                    queue_item(hrle_pkg::CMD_END_SEC, rnd_byte(), rnd_addr());
                end
                else
                begin
                    n = $urandom_range(0, 5);
                    for (int i = 0; i < n; i++)
                    begin
                        queue_item(hrle_pkg::CMD_DATA, rnd_byte(), rnd_addr());
                    end
                    queue_item(hrle_pkg::CMD_END_SEC, rnd_byte(), rnd_addr());
                    queue_item(hrle_pkg::CMD_END_SEC, rnd_byte(), rnd_addr());
                end
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    queue_item(2'($urandom_range(0, 3)), rnd_byte(), rnd_addr());
                end
            end
        end

        while (pending_items.size() != 0 || in_valid || exp_chars.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
        if (exp_chars.size() != 0)
        begin
            report("characters never sent", 16'(exp_chars.size()), 16'h0);
        end
        if (mismatch_count == 0)
        begin
            $display("hex_record_line_encoder_tb passed");
        end
        else
        begin
            $display("hex_record_line_encoder_tb failed");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("hex_record_line_encoder_tb failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/hrle_pkg.sv
rtl/hrle_buf.sv
rtl/hrle_fmt.sv
rtl/hex_record_line_encoder.sv
tb/sv/hex_record_line_encoder_tb.sv
